[hdl/bpci_pkg.sv]
// ----------------------------------------------------------------------------
// bpci_pkg: shared types, constants and lookup tables
// Holds the pressure and boiling-temperature breakpoint tables, the
// datapath widths and the divider status type.
// ----------------------------------------------------------------------------
`default_nettype none

package bpci_pkg;

	// Breakpoint table size and index width
	localparam int TABLE_POINTS = 79;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	// Field widths
	localparam int P_W    = 16;   // pressure, 1/16 mbar
	localparam int T_W    = 16;   // temperature, 1/256 degC
	localparam int XM_W   = 12;   // breakpoint pressure, whole mbar
	localparam int YC_W   = 14;   // breakpoint temperature, 1/100 degC

	// Datapath widths
	localparam int DIV_W  = 54;   // numerator and running products, signed
	localparam int DEN_W  = 28;   // denominator, signed
	localparam int D_W    = 14;   // offsets and breakpoint differences, signed
	localparam int TERM_W = 32;   // one rounded term and the running sum, signed

	// Clamp limits in whole mbar, and in 1/16 mbar
	localparam int P_MIN_MBAR = 50;
	localparam int P_MAX_MBAR = 2150;
	localparam logic [P_W-1:0] P_LO = P_W'(P_MIN_MBAR * 16);
	localparam logic [P_W-1:0] P_HI = P_W'(P_MAX_MBAR * 16);

	// Temperature table is in 1/100 degC
	localparam int DEN_SCALE = 100;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam logic [XM_W-1:0] PRESS_MBAR [TABLE_POINTS] = '{
		12'd50,   12'd100,  12'd150,  12'd200,  12'd250,  12'd300,  12'd350,
		12'd400,  12'd450,  12'd500,  12'd550,  12'd600,  12'd650,  12'd700,
		12'd750,  12'd800,  12'd850,  12'd900,  12'd905,  12'd910,  12'd915,
		12'd920,  12'd925,  12'd930,  12'd935,  12'd940,  12'd945,  12'd950,
		12'd955,  12'd960,  12'd965,  12'd970,  12'd975,  12'd980,  12'd985,
		12'd990,  12'd995,  12'd1000, 12'd1005, 12'd1010, 12'd1015, 12'd1020,
		12'd1025, 12'd1030, 12'd1035, 12'd1040, 12'd1045, 12'd1050, 12'd1055,
		12'd1060, 12'd1065, 12'd1070, 12'd1075, 12'd1080, 12'd1085, 12'd1090,
		12'd1095, 12'd1100, 12'd1150, 12'd1200, 12'd1250, 12'd1300, 12'd1350,
		12'd1400, 12'd1450, 12'd1500, 12'd1550, 12'd1600, 12'd1650, 12'd1700,
		12'd1750, 12'd1800, 12'd1850, 12'd1900, 12'd1950, 12'd2000, 12'd2050,
		12'd2100, 12'd2150
	};

	localparam logic [YC_W-1:0] TEMP_CENTI [TABLE_POINTS] = '{
		14'd3288,  14'd4582,  14'd5398,  14'd6007,  14'd6498,  14'd6911,
		14'd7270,  14'd7588,  14'd7874,  14'd8134,  14'd8373,  14'd8595,
		14'd8802,  14'd8996,  14'd9178,  14'd9351,  14'd9515,  14'd9671,
		14'd9687,  14'd9702,  14'd9717,  14'd9732,  14'd9747,  14'd9762,
		14'd9776,  14'd9791,  14'd9806,  14'd9821,  14'd9835,  14'd9850,
		14'd9864,  14'd9878,  14'd9893,  14'd9907,  14'd9921,  14'd9935,
		14'd9949,  14'd9963,  14'd9977,  14'd9991,  14'd10005, 14'd10019,
		14'd10032, 14'd10046, 14'd10060, 14'd10073, 14'd10087, 14'd10100,
		14'd10114, 14'd10127, 14'd10140, 14'd10154, 14'd10167, 14'd10180,
		14'd10193, 14'd10206, 14'd10219, 14'd10232, 14'd10359, 14'd10481,
		14'd10599, 14'd10714, 14'd10825, 14'd10932, 14'd11036, 14'd11138,
		14'd11237, 14'd11333, 14'd11426, 14'd11518, 14'd11607, 14'd11694,
		14'd11779, 14'd11863, 14'd11944, 14'd12024, 14'd12102, 14'd12179,
		14'd12254
	};

	// Breakpoint pressure in whole mbar; indexes past the table read zero
	function automatic logic [XM_W-1:0] press_mbar(input logic [IDX_W-1:0] idx);
		logic [XM_W-1:0] v;
		v = '0;
		if (int'(idx) < TABLE_POINTS) begin
			v = PRESS_MBAR[idx];
		end
		return v;
	endfunction

	// Breakpoint temperature in 1/100 degC; indexes past the table read zero
	function automatic logic [YC_W-1:0] temp_centi(input logic [IDX_W-1:0] idx);
		logic [YC_W-1:0] v;
		v = '0;
		if (int'(idx) < TABLE_POINTS) begin
			v = TEMP_CENTI[idx];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[hdl/boiling_point_cubic_interpolator.sv]
// ----------------------------------------------------------------------------
// boiling_point_cubic_interpolator: water boiling point from pressure
// Cubic Lagrange interpolation over a 79-point breakpoint table.
// ----------------------------------------------------------------------------
// Converts a pressure in 1/16 mbar to a boiling temperature in 1/256 degC.
// Pressures outside 50..2150 mbar are clamped and flagged with out_of_range.
// One item is worked at a time: in_stall stays high from the accepted beat
// until the result is loaded into the output register, once that register
// is free. A binary search of the breakpoints and the window start come
// first. Each of the four terms then loads its table values, builds the
// term's numerator and denominator on the shared multiplier, and runs the
// bit-serial restoring divider for its 54 quotient bits between a start and
// a finish step. A last step rounds the sum into the output register. A
// finished result waits in the output register while the next beat is
// accepted.
`default_nettype none

module boiling_point_cubic_interpolator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [bpci_pkg::P_W-1:0]     pressure,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [bpci_pkg::T_W-1:0]          temperature,
	output logic                              out_of_range
);
	import bpci_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DIVGO = 3'd4;
	localparam logic [2:0] S_DIVW  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_POINTS - 1);
	localparam logic [IDX_W-1:0] LAST_START = IDX_W'(TABLE_POINTS - 4);
	localparam int               PROD_W     = DIV_W + D_W;

	logic [2:0]              state_q;
	logic [P_W-1:0]          p_q;
	logic                    flag_q;
	logic [IDX_W-1:0]        lo_q;
	logic [IDX_W-1:0]        hi_q;
	logic [IDX_W-1:0]        start_q;
	logic [1:0]              k_q;
	logic [1:0]              m_q;
	logic                    ph_q;
	logic signed [DIV_W-1:0] num_q;
	logic signed [DIV_W-1:0] den_q;
	logic signed [TERM_W-1:0] sum_q;
	logic                    out_valid_q;
	logic [T_W-1:0]          temperature_q;
	logic                    out_of_range_q;

	logic                    in_acc;
	logic [P_W-1:0]          p_clamp;
	logic                    p_flag;
	logic [IDX_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid;
	logic                    mid_ge;
	logic [IDX_W-1:0]        start_d;
	logic [IDX_W-1:0]        idx_k;
	logic [IDX_W-1:0]        idx_m;
	logic [XM_W-1:0]         x_k;
	logic [XM_W-1:0]         x_m;
	logic signed [P_W:0]     dm_full;
	logic signed [XM_W:0]    dx_full;
	logic signed [D_W-1:0]   dm;
	logic signed [D_W-1:0]   dx;
	logic signed [DIV_W-1:0] mul_a;
	logic signed [D_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                    out_free;
	logic signed [TERM_W:0]  sum_rnd;
	logic [T_W-1:0]          t_sat;
	logic                    div_start;
	div_stat_t               div_st;
	logic signed [TERM_W-1:0] div_quot;

	// Input handshake and clamping
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign p_flag   = (pressure < P_LO) || (pressure > P_HI);
	assign p_clamp  = (pressure < P_LO) ? P_LO : ((pressure > P_HI) ? P_HI : pressure);

	// Binary search: smallest j with 16*x[j] >= p, j in 1..N-1
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];
	assign mid_ge  = ({press_mbar(mid), 4'b0000} >= p_q);

	// Window start is j-2 moved inside the table
	always_comb begin
		if (lo_q < IDX_W'(2)) begin
			start_d = '0;
		end else if ((lo_q - IDX_W'(2)) > LAST_START) begin
			start_d = LAST_START;
		end else begin
			start_d = lo_q - IDX_W'(2);
		end
	end

	// Window reads and offsets
	assign idx_k   = start_q + IDX_W'(k_q);
	assign idx_m   = start_q + IDX_W'(m_q);
	assign x_k     = press_mbar(idx_k);
	assign x_m     = press_mbar(idx_m);
	assign dm_full = signed'({1'b0, p_q}) - signed'({1'b0, x_m, 4'b0000});
	assign dx_full = signed'({1'b0, x_k}) - signed'({1'b0, x_m});
	assign dm      = dm_full[D_W-1:0];
	assign dx      = {dx_full[XM_W], dx_full};

	// Shared multiplier: numerator phase, then denominator phase
	assign mul_a = ph_q ? den_q : num_q;
	assign mul_b = ph_q ? dx : dm;
	assign prod  = mul_a * mul_b;

	// Divider for the rounded term
	assign div_start = (state_q == S_DIVGO);

	bpci_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (signed'(den_q[DEN_W-1:0])),
		.stat   (div_st),
		.quot   (div_quot)
	);

	// Round the sum to 1/256 degC and saturate
	assign sum_rnd = {sum_q[TERM_W-1], sum_q} + (TERM_W+1)'(128);
	always_comb begin
		if (sum_q < 0) begin
			t_sat = '0;
		end else if (sum_rnd[TERM_W:8] > (TERM_W-7)'({T_W{1'b1}})) begin
			t_sat = {T_W{1'b1}};
		end else begin
			t_sat = sum_rnd[T_W+7:8];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			m_q     <= '0;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (lo_q == hi_q) begin
						k_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					m_q     <= '0;
					ph_q    <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (m_q == k_q) begin
						if (m_q == 2'd3) begin
							state_q <= S_DIVGO;
						end else begin
							m_q <= m_q + 1'b1;
						end
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (m_q == 2'd3) begin
							state_q <= S_DIVGO;
						end else begin
							m_q <= m_q + 1'b1;
						end
					end
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_st.done) begin
						if (k_q == 2'd3) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_q    <= p_clamp;
			flag_q <= p_flag;
			lo_q   <= IDX_W'(1);
			hi_q   <= LAST_IDX;
		end
		if (state_q == S_SRCH) begin
			if (lo_q == hi_q) begin
				start_q <= start_d;
				sum_q   <= '0;
			end else if (mid_ge) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + 1'b1;
			end
		end
		if (state_q == S_LOAD) begin
			num_q <= signed'({{(DIV_W-YC_W-4){1'b0}}, temp_centi(idx_k), 4'b0000});
			den_q <= DIV_W'(DEN_SCALE);
		end
		if ((state_q == S_MUL) && (m_q != k_q)) begin
			if (!ph_q) begin
				num_q <= prod[DIV_W-1:0];
			end else begin
				den_q <= prod[DIV_W-1:0];
			end
		end
		if ((state_q == S_DIVW) && div_st.done) begin
			sum_q <= sum_q + div_quot;
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			temperature_q  <= t_sat;
			out_of_range_q <= flag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign temperature  = temperature_q;
	assign out_of_range = out_of_range_q;

	// Checks
	a_accept_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_SRCH))
		else $error("accepted beat did not start the segment search");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_div_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == S_DIVW))
		else $error("divider busy outside the divide wait");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result beat raised outside the finish step");

endmodule

`default_nettype wire

[hdl/bpci_div.sv]
// ----------------------------------------------------------------------------
// bpci_div: signed divide with round to nearest
// Restoring radix-2 divider, one quotient bit per cycle. Works on
// magnitudes, rounds halves away from zero, then restores the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module bpci_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic signed [bpci_pkg::DIV_W-1:0]     num,
	input  wire logic signed [bpci_pkg::DEN_W-1:0]     den,
	output bpci_pkg::div_stat_t                        stat,
	output logic signed [bpci_pkg::TERM_W-1:0]         quot
);
	import bpci_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [DIV_W-1:0]   dvd_q;
	logic [DEN_W-1:0]   ud_q;
	logic [DEN_W-1:0]   rem_q;

	logic [DIV_W-1:0]   un;
	logic [DEN_W-1:0]   ud;
	logic [DEN_W-1:0]   rem_sh;
	logic               ge;
	logic signed [DIV_W-1:0] q_signed;

	// Magnitudes of the operands
	assign un = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
	assign ud = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

	// Shift in the next dividend bit and trial-subtract
	assign rem_sh = {rem_q[DEN_W-2:0], dvd_q[DIV_W-1]};
	assign ge     = (rem_sh >= ud_q);

	// Sequence the bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the rounded dividend, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DIV_W-1] ^ den[DEN_W-1];
			dvd_q <= un + DIV_W'(ud >> 1);
			ud_q  <= ud;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - ud_q) : rem_sh;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	// Restore the sign
	assign q_signed = neg_q ? -signed'(dvd_q) : signed'(dvd_q);
	assign quot     = q_signed[TERM_W-1:0];

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: boiling point cubic interpolator testbench
// Sends pressure beats through the valid/stall input channel and checks every
// temperature beat against an in-bench cubic Lagrange predictor built on the
// package breakpoint tables. Both channels idle at random, except for one
// stretch of back-to-back traffic in the middle of the run.
// ----------------------------------------------------------------------------

module tb_top;
	import bpci_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_BEATS = 1500;
	localparam int DRAIN_CYCLES = 400;
	localparam int IDLE_PCT     = 17;

	typedef struct packed {
		logic [T_W-1:0] temperature;
		logic           out_of_range;
	} boil_reading_t;

	// Predicts the boiling temperature of each accepted pressure and checks
	// returned beats in order
	class boil_scoreboard;
		boil_reading_t pending_readings[$];
		int unsigned   errors;

		function new();
			errors = 0;
		endfunction

		// Divide, rounding to nearest with halves away from zero
		static function longint div_round(longint num, longint den);
			longint un;
			longint ud;
			longint q;
			bit     neg;
			neg = (num < 0) != (den < 0);
			un  = (num < 0) ? -num : num;
			ud  = (den < 0) ? -den : den;
			q   = (un + ud / 2) / ud;
			return neg ? -q : q;
		endfunction

		static function boil_reading_t interpolate(logic [P_W-1:0] raw);
			boil_reading_t r;
			longint        p;
			longint        lo_p;
			longint        hi_p;
			longint        num;
			longint        den;
			longint        sum;
			longint        t;
			int            seg;
			int            first;
			bit            found;
			lo_p  = longint'(PRESS_MBAR[0]) * 16;
			hi_p  = longint'(PRESS_MBAR[TABLE_POINTS-1]) * 16;
			p     = longint'(raw);
			r.out_of_range = 1'b0;
			// Clamp into the table span and flag it
			if (p < lo_p) begin
				p = lo_p;
				r.out_of_range = 1'b1;
			end
			if (p > hi_p) begin
				p = hi_p;
				r.out_of_range = 1'b1;
			end
			// Find the segment whose upper breakpoint is at or above p
			seg   = TABLE_POINTS - 2;
			found = 1'b0;
			for (int i = 0; i < TABLE_POINTS - 1; i++) begin
				if (!found && longint'(PRESS_MBAR[i+1]) * 16 >= p) begin
					seg   = i;
					found = 1'b1;
				end
			end
			// Keep the four-point window inside the table
			first = seg - 1;
			if (first < 0) begin
				first = 0;
			end
			if (first > TABLE_POINTS - 4) begin
				first = TABLE_POINTS - 4;
			end
			// Sum the four Lagrange terms in 1/65536 degC
			sum = 0;
			for (int k = 0; k < 4; k++) begin
				num = longint'(TEMP_CENTI[first+k]) * 16;
				den = DEN_SCALE;
				for (int m = 0; m < 4; m++) begin
					if (m != k) begin
						num = num * (p - longint'(PRESS_MBAR[first+m]) * 16);
						den = den * (longint'(PRESS_MBAR[first+k])
							- longint'(PRESS_MBAR[first+m]));
					end
				end
				sum += div_round(num, den);
			end
			// Round to 1/256 degC and saturate
			if (sum < 0) begin
				t = 0;
			end else begin
				t = (sum + 128) >>> 8;
				if (t > 65535) begin
					t = 65535;
				end
			end
			r.temperature = T_W'(t);
			return r;
		endfunction

		function void note_pressure(logic [P_W-1:0] raw);
			pending_readings.push_back(interpolate(raw));
		endfunction

		function void check_reading(logic [T_W-1:0] temp, logic flag);
			boil_reading_t exp_r;
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected beat, temperature %0d out_of_range %0d",
					$time, temp, flag);
				errors++;
				return;
			end
			exp_r = pending_readings.pop_front();
			if (temp !== exp_r.temperature) begin
				$display("%0t: temperature mismatch, expected %0d actual %0d",
					$time, exp_r.temperature, temp);
				errors++;
			end
			if (flag !== exp_r.out_of_range) begin
				$display("%0t: out_of_range mismatch, expected %0d actual %0d",
					$time, exp_r.out_of_range, flag);
				errors++;
			end
		endfunction
	endclass

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           in_valid     = 1'b0;
	logic           in_stall;
	logic [P_W-1:0] pressure     = '0;
	logic           out_valid;
	logic           out_stall    = 1'b0;
	logic [T_W-1:0] temperature;
	logic           out_of_range;

	bit             steady_traffic = 1'b0;
	int unsigned    cycle_count    = 0;
	boil_scoreboard sb             = new();

	boiling_point_cubic_interpolator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pressure     (pressure),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temperature  (temperature),
		.out_of_range (out_of_range)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check each accepted result beat, then pick the next cycle's stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_reading(temperature, out_of_range);
		end
		out_stall <= !steady_traffic && ($urandom_range(99) < IDLE_PCT);
	end

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Present one pressure beat, idling at random first, and hold until taken
	task automatic send_pressure(input logic [P_W-1:0] p);
		while (!steady_traffic && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pressure <= p;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_pressure(p);
	endtask

	// Pick a random pressure: mostly in range, some on or beside breakpoints, some anywhere
	function automatic logic [P_W-1:0] random_pressure();
		int unsigned pick;
		int          bp;
		pick = $urandom_range(99);
		if (pick < 55) begin
			return P_W'($urandom_range(P_HI, P_LO));
		end else if (pick < 72) begin
			bp = int'(PRESS_MBAR[$urandom_range(TABLE_POINTS - 1)]) * 16;
			return P_W'(bp + $urandom_range(4) - 2);
		end else if (pick < 85) begin
			// dense stretch of 5 mbar breakpoints
			return P_W'($urandom_range(17600, 14400));
		end
		return P_W'($urandom_range(65535));
	endfunction

	initial begin
		logic [P_W-1:0] directed[$];
		directed = '{
			16'd0,     16'hFFFF,  16'd799,   16'd800,   16'd801,   16'd1600,
			16'd1601,  16'd2400,  16'd14400, 16'd14480, 16'd14481, 16'd16000,
			16'd17600, 16'd17601, 16'd33600, 16'd33601, 16'd34000, 16'd34399,
			16'd34400, 16'd34401, 16'h5555,  16'hAAAA
		};

		// Hold reset, then release it at an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats: ends of the field, clamps, first and last segments
		foreach (directed[i]) begin
			send_pressure(directed[i]);
		end

		// Random beats with a back-to-back stretch in the middle
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			steady_traffic = (n >= 600) && (n < 900);
			send_pressure(random_pressure());
		end
		steady_traffic = 1'b0;
		in_valid <= 1'b0;

		// Drain, then watch for stray beats
		while (sb.pending_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/bpci_pkg.sv
hdl/bpci_div.sv
hdl/boiling_point_cubic_interpolator.sv
dv/tb_top.sv
